[design/b64enc_pkg.sv]
// Package: shared types, constants and the symbol alphabet of the base64 stream encoder.
`timescale 1ns / 1ps
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxChars   = 4;
  localparam logic [6:0]  PadChar    = 7'd61;

  typedef logic [6:0] char_t;
  typedef logic [5:0] sym_t;

  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic  [1:0]          last_idx;
    logic                 eom;
  } job_t;

  function automatic char_t sym_to_char(input sym_t sym);
    char_t c;
    case (sym) inside
      [6'd0:6'd25]:  c = 7'(7'd90 - 7'(sym));
      [6'd26:6'd51]: c = 7'(7'd122 - 7'(sym - 6'd26));
      6'd52:         c = 7'd48;
      [6'd53:6'd61]: c = 7'(7'd57 - 7'(sym - 6'd53));
      6'd62:         c = 7'd43;
      default:       c = 7'd47;
    endcase
    return c;
  endfunction

endpackage

[design/b64enc_in_if.sv]
// Interface: byte input channel with valid/ready handshake.
`timescale 1ns / 1ps
interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

[design/b64enc_out_if.sv]
// Interface: character output channel with valid/ready handshake.
`timescale 1ns / 1ps
interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

[design/base64_stream_encoder.sv]
// Top level of the base64 stream encoder.
// Encodes a byte stream into base64 characters over a reordered alphabet
// (Z..A, z..a, 0 9..1, +, /), one character per cycle on the output channel
// while it is ready. A byte yields one character at group positions one
// and two and two at position three; the last byte of a message that ends
// inside a group also emits the zero-filled remainder symbol and '=' pads
// up to four characters, and final_char marks the last character of the
// message. The character emitter sets the rate: it holds a byte's job until
// it has put out all its characters (1, 2, 3 or 4): on long streams four
// characters for every three bytes, two for the byte that closes a group. A
// job queue lets bytes be taken while earlier characters still drain.
`timescale 1ns / 1ps
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64enc_pkg::QueueDepth
) (
  input logic         clk,
  input logic         rst_n,
  b64enc_in_if.sink   in_ch,
  b64enc_out_if.source out_ch
);

  logic             f_valid, f_ready, q_valid, q_ready;
  b64enc_pkg::job_t f_job, q_job;

  b64enc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data_byte),
    .in_end_of_message (in_ch.end_of_message),
    .job_valid         (f_valid),
    .job_ready         (f_ready),
    .job               (f_job)
  );

  b64enc_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .out_final (out_ch.final_char)
  );

endmodule

[design/b64enc_front.sv]
// Front end: accepts bytes, tracks group phase and leftover bits, builds character jobs.
`timescale 1ns / 1ps
module b64enc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_message,
  output logic             job_valid,
  input  logic             job_ready,
  output b64enc_pkg::job_t job
);

  logic [1:0]       phase_r, phase_nxt;
  logic [3:0]       left_r, left_nxt;
  b64enc_pkg::sym_t s0, s1;
  logic             take;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign take      = in_valid && job_ready;

  always_comb begin
    s0        = '0;
    s1        = '0;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    job.chars = '0;
    job.eom   = in_end_of_message;
    case (phase_r)
      2'd1: begin
        s0           = {left_r[1:0], in_data_byte[7:4]};
        s1           = {in_data_byte[3:0], 2'b00};
        left_nxt     = in_data_byte[3:0];
        phase_nxt    = 2'd2;
        job.chars[0] = b64enc_pkg::sym_to_char(s0);
        job.chars[1] = b64enc_pkg::sym_to_char(s1);
        job.chars[2] = b64enc_pkg::PadChar;
        job.last_idx = in_end_of_message ? 2'd2 : 2'd0;
      end
      2'd2: begin
        s0           = {left_r, in_data_byte[7:6]};
        s1           = in_data_byte[5:0];
        left_nxt     = '0;
        phase_nxt    = 2'd0;
        job.chars[0] = b64enc_pkg::sym_to_char(s0);
        job.chars[1] = b64enc_pkg::sym_to_char(s1);
        job.last_idx = 2'd1;
      end
      default: begin
        s0           = in_data_byte[7:2];
        s1           = {in_data_byte[1:0], 4'b0000};
        left_nxt     = {2'b00, in_data_byte[1:0]};
        phase_nxt    = 2'd1;
        job.chars[0] = b64enc_pkg::sym_to_char(s0);
        job.chars[1] = b64enc_pkg::sym_to_char(s1);
        job.chars[2] = b64enc_pkg::PadChar;
        job.chars[3] = b64enc_pkg::PadChar;
        job.last_idx = in_end_of_message ? 2'd3 : 2'd0;
      end
    endcase
    if (in_end_of_message) begin
      phase_nxt = 2'd0;
      left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

[design/b64enc_queue.sv]
// Job queue: short FIFO between the front end and the character emitter.
`timescale 1ns / 1ps
module b64enc_queue #(
  parameter int unsigned Depth = b64enc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  b64enc_pkg::job_t push_job,
  output logic             pop_valid,
  input  logic             pop_ready,
  output b64enc_pkg::job_t pop_job
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64enc_pkg::job_t    mem_r [Depth];
  logic [PtrW-1:0]     wptr_r, rptr_r;
  logic [CntW-1:0]     cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LastPtr) ? '0 : PtrW'(wptr_r + 1'b1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LastPtr) ? '0 : PtrW'(rptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= CntW'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= CntW'(cnt_r - 1'b1);
      end
    end
  end

endmodule

[design/b64enc_back.sv]
// Back end: walks each job one character per cycle into the output register while the output is ready.
`timescale 1ns / 1ps
module b64enc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  b64enc_pkg::job_t job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       out_char,
  output logic             out_final
);

  logic [1:0] idx_r;
  logic       ovalid_r;
  logic [6:0] char_r;
  logic       final_r;
  logic       load, at_end;

  assign load      = job_valid && (!ovalid_r || out_ready);
  assign at_end    = (idx_r == job.last_idx);
  assign job_ready = load && at_end;
  assign out_valid = ovalid_r;
  assign out_char  = char_r;
  assign out_final = final_r;

  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= job.chars[idx_r];
      final_r <= job.eom && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (load) begin
        ovalid_r <= 1'b1;
        idx_r    <= at_end ? 2'd0 : 2'(idx_r + 1'b1);
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

endmodule
